// ===== rtl/sgbe_pkg.sv =====
`timescale 1ns / 1ps

package sgbe_pkg;

    // fixed point format and level limit
    localparam int FRAC_BITS      = 24;
    localparam int MAX_LEVEL      = 16;
    localparam int GRID_DEPTH_DEF = 1024;

    // field widths
    localparam int COORD_W = 25;
    localparam int LEVEL_W = 5;
    localparam int INDEX_W = 16;
    localparam int COEF_W  = 32;
    localparam int VALUE_W = 64;
    localparam int POINT_W = 2 * LEVEL_W + 2 * INDEX_W;

    // scaled coordinate width, basis width, pair width
    localparam int SW = COORD_W + MAX_LEVEL + 1;
    localparam int BW = FRAC_BITS + 2;
    localparam int PW = FRAC_BITS + 4;
    // product widths of the term stage
    localparam int MH_W   = COEF_W + PW - FRAC_BITS + 1;
    localparam int ML_W   = COEF_W + FRAC_BITS + 1;
    localparam int TERM_W = MH_W + 1;

    localparam logic [SW-1:0] CAP = (SW'(1) << (FRAC_BITS + 2)) - SW'(1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_ACCUM = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_READ,
        S_DONE
    } t_state;

    // configuration register indexes
    localparam logic CFG_BASIS_MODE = 1'b0;
    localparam logic CFG_GRID_COUNT = 1'b1;

    // status of the term pipeline
    typedef struct packed {
        logic busy;
        logic out_valid;
    } t_pipe_stat;

    // 1D hat or modified linear basis value, clipped to the Q2 maximum
    function automatic logic [BW-1:0] basis_1d(
        logic [COORD_W-1:0] x,
        logic [LEVEL_W-1:0] lev,
        logic [INDEX_W-1:0] idx,
        logic               modified
    );
        logic [LEVEL_W-1:0] l;
        logic [SW-1:0]      s;
        logic [SW-1:0]      ic;
        logic [SW-1:0]      one;
        logic [SW-1:0]      two;
        logic [SW-1:0]      spo;
        logic [SW-1:0]      d;
        logic [SW-1:0]      r;
        logic [INDEX_W:0]   top_idx;
        l       = (lev > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : lev;
        s       = SW'(x) << l;
        ic      = SW'(idx) << FRAC_BITS;
        one     = SW'(1) << FRAC_BITS;
        two     = one << 1;
        spo     = s + one;
        d       = (s > ic) ? (s - ic) : (ic - s);
        top_idx = ((INDEX_W + 1)'(1) << l) - (INDEX_W + 1)'(1);
        if (modified && (l == LEVEL_W'(1))) begin
            r = one;
        end else if (modified && (idx == INDEX_W'(1))) begin
            r = (two > s) ? (two - s) : '0;
        end else if (modified && ({1'b0, idx} == top_idx)) begin
            r = (spo > ic) ? (spo - ic) : '0;
        end else begin
            r = (d < one) ? (one - d) : '0;
        end
        return (r > CAP) ? CAP[BW-1:0] : r[BW-1:0];
    endfunction

    // saturating 64-bit add, clip flag in the top bit
    function automatic logic [VALUE_W:0] sat_add(
        logic signed [VALUE_W-1:0] a,
        logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] t;
        t = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (t[VALUE_W] != t[VALUE_W-1]) begin
            return {1'b1, t[VALUE_W], {(VALUE_W - 1){~t[VALUE_W]}}};
        end
        return {1'b0, t[VALUE_W-1:0]};
    endfunction

endpackage

// ===== rtl/sparse_grid_basis_eval_2d.sv =====
`timescale 1ns / 1ps
// Eval and accumulate walk min(grid_count, GRID_DEPTH) points, one per cycle through the
// point memory read port, and deliver their word once the term pipeline has drained.
// Load and read deliver their word without a walk. One op is in flight at a time.
// Reset (synchronous, active low) clears control and configuration, then runs a
// clearing pass over every accumulator memory entry before taking words.
module sparse_grid_basis_eval_2d #(
    parameter int GRID_DEPTH = sgbe_pkg::GRID_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // slot[9:0] level_x[14:10] level_y[19:15] index_x[35:20] index_y[51:36]
    // coef[83:52] coord_x[108:84] coord_y[133:109], zero pad [135:134]
    input  logic [135:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // value[63:0]
    output logic [63:0]  o_m_axis_tdata,
    // saturated[0]
    output logic [0:0]   o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [10:0]  i_cfg_data
);

    localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int CW = $clog2(GRID_DEPTH + 1);
    localparam int VW = sgbe_pkg::VALUE_W;
    localparam int MW = sgbe_pkg::POINT_W + sgbe_pkg::COEF_W;

    sgbe_pkg::t_state r_state, n_state;

    logic [MW-1:0] r_grid_mem [GRID_DEPTH];
    logic [VW-1:0] r_acc_mem  [GRID_DEPTH];

    logic                               r_basis_mode;
    logic [10:0]                        r_grid_count;
    logic [CW-1:0]                      r_idx;
    logic [CW-1:0]                      r_n;
    sgbe_pkg::t_op                      r_op;
    logic                               r_slot_ok;
    logic signed [sgbe_pkg::COEF_W-1:0] r_coef;
    logic [sgbe_pkg::COORD_W-1:0]       r_cx, r_cy;
    logic signed [VW-1:0]               r_sum;
    logic                               r_clip;
    logic                               r_rd_v;
    logic [AW-1:0]                      r_rd_addr;
    logic [MW-1:0]                      r_grid_q;
    logic [VW-1:0]                      r_acc_q;
    logic                               r_ovalid;
    logic [VW-1:0]                      r_odata;
    logic                               r_osat;

    logic                 accept;
    logic                 slot_ok;
    logic                 walk_en;
    logic                 walk_last;
    logic                 out_free;
    logic                 acc_rd_en;
    logic [AW-1:0]        acc_raddr;
    logic                 acc_we;
    logic [AW-1:0]        acc_waddr;
    logic [VW-1:0]        acc_wdata;
    logic [CW-1:0]        n_count;
    logic [VW:0]          upd;
    logic signed [sgbe_pkg::COEF_W-1:0] term_coef;

    sgbe_pkg::t_pipe_stat        pipe_stat;
    logic [AW-1:0]               pipe_addr;
    logic [VW-1:0]               pipe_acc;
    logic signed [VW-1:0]        pipe_term;

    // decode the input word and the walk bound
    always_comb begin
        accept   = i_s_axis_tvalid & o_s_axis_tready;
        slot_ok  = (32'(i_s_axis_tdata[9:0]) < GRID_DEPTH);
        out_free = ~r_ovalid | i_m_axis_tready;
        n_count  = (32'(r_grid_count) > GRID_DEPTH) ? CW'(GRID_DEPTH) : CW'(r_grid_count);
        walk_last = (r_idx == r_n);
        upd      = sgbe_pkg::sat_add((r_op == sgbe_pkg::OP_EVAL) ? r_sum : $signed(pipe_acc),
                                     pipe_term);
        term_coef = (r_op == sgbe_pkg::OP_EVAL) ?
                    $signed(r_grid_q[MW-1:sgbe_pkg::POINT_W]) : r_coef;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgbe_pkg::S_CLEAR: begin
                if (r_idx == CW'(GRID_DEPTH - 1)) n_state = sgbe_pkg::S_IDLE;
            end
            sgbe_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == sgbe_pkg::OP_EVAL ||
                        i_s_axis_tuser == sgbe_pkg::OP_ACCUM) begin
                        n_state = sgbe_pkg::S_WALK;
                    end else begin
                        n_state = sgbe_pkg::S_READ;
                    end
                end
            end
            sgbe_pkg::S_WALK: begin
                if (walk_last) n_state = sgbe_pkg::S_DRAIN;
            end
            sgbe_pkg::S_DRAIN: begin
                if (!r_rd_v && !pipe_stat.busy) n_state = sgbe_pkg::S_DONE;
            end
            sgbe_pkg::S_READ: begin
                n_state = sgbe_pkg::S_DONE;
            end
            sgbe_pkg::S_DONE: begin
                if (out_free) n_state = sgbe_pkg::S_IDLE;
            end
            default: n_state = sgbe_pkg::S_CLEAR;
        endcase
    end

    // state outputs and memory port selection
    always_comb begin
        o_s_axis_tready = (r_state == sgbe_pkg::S_IDLE);
        walk_en   = (r_state == sgbe_pkg::S_WALK) && !walk_last;
        acc_rd_en = walk_en ||
                    (accept && (i_s_axis_tuser == sgbe_pkg::OP_READ));
        acc_raddr = walk_en ? r_idx[AW-1:0] : AW'(i_s_axis_tdata[9:0]);
        acc_we    = 1'b0;
        acc_waddr = pipe_addr;
        acc_wdata = upd[VW-1:0];
        if (r_state == sgbe_pkg::S_CLEAR) begin
            acc_we    = 1'b1;
            acc_waddr = r_idx[AW-1:0];
            acc_wdata = '0;
        end else if (accept && (i_s_axis_tuser == sgbe_pkg::OP_LOAD) && slot_ok) begin
            acc_we    = 1'b1;
            acc_waddr = AW'(i_s_axis_tdata[9:0]);
            acc_wdata = '0;
        end else if (pipe_stat.out_valid && (r_op == sgbe_pkg::OP_ACCUM)) begin
            acc_we    = 1'b1;
        end
    end

    // point and coefficient memory
    always_ff @(posedge i_clk) begin
        if (accept && (i_s_axis_tuser == sgbe_pkg::OP_LOAD) && slot_ok) begin
            r_grid_mem[AW'(i_s_axis_tdata[9:0])] <= {i_s_axis_tdata[83:52],
                                                     i_s_axis_tdata[51:10]};
        end
        if (walk_en) r_grid_q <= r_grid_mem[r_idx[AW-1:0]];
    end

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (acc_we) r_acc_mem[acc_waddr] <= acc_wdata;
        if (acc_rd_en) r_acc_q <= r_acc_mem[acc_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sgbe_pkg::S_CLEAR;
            r_basis_mode <= 1'b0;
            r_grid_count <= '0;
            r_idx        <= '0;
            r_rd_v       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= walk_en;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgbe_pkg::CFG_BASIS_MODE: r_basis_mode <= i_cfg_data[0];
                    sgbe_pkg::CFG_GRID_COUNT: r_grid_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == sgbe_pkg::S_CLEAR || walk_en) begin
                r_idx <= r_idx + CW'(1);
            end else if (accept) begin
                r_idx <= '0;
            end
            if (r_state == sgbe_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // op capture, sums and the output word
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_idx[AW-1:0];
        if (accept) begin
            r_op      <= sgbe_pkg::t_op'(i_s_axis_tuser);
            r_slot_ok <= slot_ok;
            r_coef    <= $signed(i_s_axis_tdata[83:52]);
            r_cx      <= i_s_axis_tdata[108:84];
            r_cy      <= i_s_axis_tdata[133:109];
            r_n       <= n_count;
            r_sum     <= '0;
            r_clip    <= 1'b0;
        end else if (r_state == sgbe_pkg::S_READ) begin
            r_sum <= (r_op == sgbe_pkg::OP_READ && r_slot_ok) ? $signed(r_acc_q) : '0;
        end else if (pipe_stat.out_valid) begin
            if (r_op == sgbe_pkg::OP_EVAL) r_sum <= $signed(upd[VW-1:0]);
            r_clip <= r_clip | upd[VW];
        end
        if (r_state == sgbe_pkg::S_DONE && out_free) begin
            r_odata <= r_sum;
            r_osat  <= r_clip;
        end
    end

    sgbe_term #(
        .AW(AW)
    ) u_term (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_rd_v),
        .i_addr    (r_rd_addr),
        .i_point   (r_grid_q[sgbe_pkg::POINT_W-1:0]),
        .i_coef    (term_coef),
        .i_acc     (r_acc_q),
        .i_coord_x (r_cx),
        .i_coord_y (r_cy),
        .i_mode    (r_basis_mode),
        .o_stat    (pipe_stat),
        .o_addr    (pipe_addr),
        .o_acc     (pipe_acc),
        .o_term    (pipe_term)
    );

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_osat;

endmodule

// ===== rtl/sgbe_term.sv =====
`timescale 1ns / 1ps

// Four-stage term pipeline: basis values, basis product, coefficient products, term.
module sgbe_term #(
    parameter int AW = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [AW-1:0]                         i_addr,
    input  logic [sgbe_pkg::POINT_W-1:0]          i_point,
    input  logic signed [sgbe_pkg::COEF_W-1:0]    i_coef,
    input  logic [sgbe_pkg::VALUE_W-1:0]          i_acc,
    input  logic [sgbe_pkg::COORD_W-1:0]          i_coord_x,
    input  logic [sgbe_pkg::COORD_W-1:0]          i_coord_y,
    input  logic                                  i_mode,
    output sgbe_pkg::t_pipe_stat                  o_stat,
    output logic [AW-1:0]                         o_addr,
    output logic [sgbe_pkg::VALUE_W-1:0]          o_acc,
    output logic signed [sgbe_pkg::VALUE_W-1:0]   o_term
);

    localparam int F  = sgbe_pkg::FRAC_BITS;
    localparam int LW = sgbe_pkg::LEVEL_W;
    localparam int IW = sgbe_pkg::INDEX_W;

    logic                                r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]                       r_a1, r_a2, r_a3, r_a4;
    logic [sgbe_pkg::VALUE_W-1:0]        r_acc1, r_acc2, r_acc3, r_acc4;
    logic signed [sgbe_pkg::COEF_W-1:0]  r_c1, r_c2;
    logic [sgbe_pkg::BW-1:0]             r_bx, r_by;
    logic [sgbe_pkg::PW-1:0]             r_pair;
    logic signed [sgbe_pkg::MH_W-1:0]    r_mh;
    logic signed [sgbe_pkg::ML_W-1:0]    r_ml;
    logic signed [sgbe_pkg::VALUE_W-1:0] r_term;

    logic [2*sgbe_pkg::BW-1:0]           n_prod;
    logic signed [sgbe_pkg::MH_W-1:0]    n_mh;
    logic signed [sgbe_pkg::ML_W-1:0]    n_ml;
    logic signed [sgbe_pkg::TERM_W-1:0]  n_term;

    // form the products and the floored term
    always_comb begin
        n_prod = (2 * sgbe_pkg::BW)'(r_bx) * (2 * sgbe_pkg::BW)'(r_by);
        n_mh   = r_c2 * $signed({1'b0, r_pair[sgbe_pkg::PW-1:F]});
        n_ml   = r_c2 * $signed({1'b0, r_pair[F-1:0]});
        n_term = sgbe_pkg::TERM_W'(r_mh) + sgbe_pkg::TERM_W'(r_ml >>> F);
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_bx   <= sgbe_pkg::basis_1d(i_coord_x, i_point[LW-1:0],
                                     i_point[2*LW+IW-1:2*LW], i_mode);
        r_by   <= sgbe_pkg::basis_1d(i_coord_y, i_point[2*LW-1:LW],
                                     i_point[2*LW+2*IW-1:2*LW+IW], i_mode);
        r_c1   <= i_coef;
        r_a1   <= i_addr;
        r_acc1 <= i_acc;
        r_pair <= n_prod[F+sgbe_pkg::PW-1:F];
        r_c2   <= r_c1;
        r_a2   <= r_a1;
        r_acc2 <= r_acc1;
        r_mh   <= n_mh;
        r_ml   <= n_ml;
        r_a3   <= r_a2;
        r_acc3 <= r_acc2;
        r_term <= sgbe_pkg::VALUE_W'(n_term);
        r_a4   <= r_a3;
        r_acc4 <= r_acc3;
    end

    assign o_stat.busy      = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_stat.out_valid = r_v4;
    assign o_addr           = r_a4;
    assign o_acc            = r_acc4;
    assign o_term           = r_term;

endmodule

// ===== tb/sgbe_checker.sv =====
`timescale 1ns / 1ps

module sgbe_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [135:0] i_s_axis_tdata,
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [63:0]  i_m_axis_tdata,
    input  logic [0:0]   i_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [10:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_word_count
);

    localparam int DEPTH = sgbe_pkg::GRID_DEPTH_DEF;
    localparam int FB    = sgbe_pkg::FRAC_BITS;

    typedef struct packed {
        logic [63:0] value;
        logic        saturated;
    } t_result;

    // shadow of the grid and its accumulators
    logic [sgbe_pkg::POINT_W-1:0] pt_mem   [DEPTH];
    logic signed [31:0]           coef_mem [DEPTH];
    logic signed [63:0]           acc_mem  [DEPTH];
    logic                         mode_q;
    logic [10:0]                  count_q;
    t_result                      result_q [$];

    // 1D basis value, hat or modified linear
    function automatic longint unsigned hat_value(longint unsigned x, int unsigned lev,
                                                  longint unsigned idx, logic modified);
        int unsigned l;
        longint unsigned s, ic, one, r, d;
        l   = (lev > sgbe_pkg::MAX_LEVEL) ? sgbe_pkg::MAX_LEVEL : lev;
        one = 64'd1 << FB;
        s   = x << l;
        ic  = idx << FB;
        if (modified && l == 1) begin
            r = one;
        end else if (modified && idx == 1) begin
            r = (2 * one > s) ? 2 * one - s : 0;
        end else if (modified && idx == ((64'd1 << l) - 1)) begin
            r = (s + one > ic) ? s + one - ic : 0;
        end else begin
            d = (s > ic) ? s - ic : ic - s;
            r = (d < one) ? one - d : 0;
        end
        if (r > ((64'd1 << (FB + 2)) - 1)) r = (64'd1 << (FB + 2)) - 1;
        return r;
    endfunction

    // weighted basis product of one point, floored
    function automatic longint point_weight(int j, longint unsigned x, longint unsigned y,
                                            longint c);
        logic [sgbe_pkg::POINT_W-1:0] g;
        longint unsigned bx, by, pair;
        longint hi, lo, p;
        g    = pt_mem[j];
        bx   = hat_value(x, g[4:0], g[25:10], mode_q);
        by   = hat_value(y, g[9:5], g[41:26], mode_q);
        pair = (bx * by) >> FB;
        hi   = longint'(pair >> FB);
        lo   = longint'(pair & ((64'd1 << FB) - 1));
        p    = c * lo;
        return c * hi + (p >>> FB);
    endfunction

    function automatic longint clip_add(longint a, longint b, ref logic clip);
        logic signed [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t[64] != t[63]) begin
            clip = 1'b1;
            return t[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        end
        return t[63:0];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // predict one word per accepted op
    task automatic predict_op(logic [1:0] op, logic [135:0] d);
        int n;
        longint sum, c, x, y;
        logic clip;
        logic [9:0] slot;
        slot = d[9:0];
        c    = longint'($signed(d[83:52]));
        x    = d[108:84];
        y    = d[133:109];
        n    = (count_q > DEPTH) ? DEPTH : count_q;
        sum  = 0;
        clip = 1'b0;
        case (sgbe_pkg::t_op'(op))
            sgbe_pkg::OP_LOAD: begin
                pt_mem[slot]   = {d[51:36], d[35:20], d[19:15], d[14:10]};
                coef_mem[slot] = d[83:52];
                acc_mem[slot]  = 0;
            end
            sgbe_pkg::OP_EVAL: begin
                for (int j = 0; j < n; j++)
                    sum = clip_add(sum, point_weight(j, x, y, coef_mem[j]), clip);
            end
            sgbe_pkg::OP_ACCUM: begin
                for (int j = 0; j < n; j++)
                    acc_mem[j] = clip_add(acc_mem[j], point_weight(j, x, y, c), clip);
            end
            default: begin
                sum = acc_mem[slot];
            end
        endcase
        result_q.push_back('{value: sum, saturated: clip});
    endtask

    initial begin
        o_fail_count = 0;
        o_word_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mode_q  = 1'b0;
            count_q = '0;
        end else begin
            // track configuration writes
            if (i_cfg_we) begin
                if (i_cfg_index == sgbe_pkg::CFG_BASIS_MODE) mode_q = i_cfg_data[0];
                else count_q = i_cfg_data;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) predict_op(i_s_axis_tuser, i_s_axis_tdata);
            // compare each delivered word with the oldest expectation
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_word_count++;
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected word", i_m_axis_tdata, 0);
                end else begin
                    want = result_q.pop_front();
                    if (i_m_axis_tdata !== want.value)
                        report_mismatch("value", i_m_axis_tdata, want.value);
                    if (i_m_axis_tuser[0] !== want.saturated)
                        report_mismatch("saturated", i_m_axis_tuser, want.saturated);
                end
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    logic         clk;
    logic         rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [135:0] s_data;
    logic [1:0]   s_user;
    logic         m_valid;
    logic         m_ready;
    logic [63:0]  m_data;
    logic [0:0]   m_user;
    logic         cfg_we;
    logic         cfg_index;
    logic [10:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           word_count;
    logic         hold_off;
    int           n_loaded;
    int           n_evals;

    sparse_grid_basis_eval_2d u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sgbe_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .i_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .i_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .i_m_axis_tdata(m_data), .i_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_word_count(word_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // random receiver stalls, plus a long hold-off on request
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic write_reg(logic idx, logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // send one word, holding it until accepted; valid stays up for a following word
    task automatic send_word(sgbe_pkg::t_op op, logic [135:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= d;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (op == sgbe_pkg::OP_EVAL || op == sgbe_pkg::OP_ACCUM) n_evals++;
    endtask

    function automatic logic [135:0] pack_word(logic [9:0] slot, logic [4:0] lx,
        logic [4:0] ly, logic [15:0] ix, logic [15:0] iy, logic [31:0] c,
        logic [24:0] x, logic [24:0] y);
        return {2'b00, y, x, c, iy, ix, ly, lx, slot};
    endfunction

    function automatic logic [24:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 25'd0;
            1: return 25'h1000000;
            2: return 25'h1ffffff;
            default: return $urandom_range(0, 25'h1000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    // a well-formed point mostly, odd index within its level
    task automatic load_point(int slot);
        logic [4:0] l1, l2;
        logic [15:0] i1, i2;
        l1 = $urandom_range(1, 6);
        l2 = $urandom_range(1, 6);
        i1 = (($urandom_range(0, (1 << l1) - 1)) << 1 | 1) & ((1 << l1) - 1);
        i2 = (($urandom_range(0, (1 << l2) - 1)) << 1 | 1) & ((1 << l2) - 1);
        if ($urandom_range(0, 9) == 0) begin
            l1 = $urandom_range(0, 31);
            i1 = $urandom;
        end
        if ($urandom_range(0, 9) == 0) begin
            l2 = $urandom_range(0, 31);
            i2 = $urandom;
        end
        send_word(sgbe_pkg::OP_LOAD,
                  pack_word(slot, l1, l2, i1, i2, rand_coef(), $urandom, $urandom));
    endtask

    // drop valid and wait until every expected word has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int items, int n);
        int k;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 9);
            if (k < 2) load_point($urandom_range(0, n + 1));
            else if (k < 5)
                send_word(sgbe_pkg::OP_EVAL, pack_word($urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, rand_coord(), rand_coord()));
            else if (k < 8)
                send_word(sgbe_pkg::OP_ACCUM, pack_word($urandom, $urandom, $urandom,
                          $urandom, $urandom, rand_coef(), rand_coord(), rand_coord()));
            else
                send_word(sgbe_pkg::OP_READ, pack_word($urandom_range(0, n_loaded - 1),
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = sgbe_pkg::OP_LOAD;
        cfg_we    = 1'b0;
        cfg_index = sgbe_pkg::CFG_BASIS_MODE;
        cfg_data  = '0;
        hold_off  = 1'b0;
        n_evals   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: load every slot used below, then hit the extremes
        n_loaded = 16;
        for (int j = 0; j < 16; j++) load_point(j);
        send_word(sgbe_pkg::OP_LOAD,
                  pack_word(10'd1, 5'd1, 5'd1, 16'd1, 16'd1, 32'h7fffffff, 0, 0));
        send_word(sgbe_pkg::OP_LOAD, pack_word(10'd2, 5'd31, 5'd0, 16'hffff, 16'd0,
                  32'h80000000, 0, 0));
        wait_idle();
        write_reg(sgbe_pkg::CFG_GRID_COUNT, 11'd4);
        send_word(sgbe_pkg::OP_EVAL, pack_word(0, 0, 0, 0, 0, 0, 25'd0, 25'h1ffffff));
        send_word(sgbe_pkg::OP_ACCUM,
                  pack_word(0, 0, 0, 0, 0, 32'h80000000, 25'h1000000, 25'd0));
        send_word(sgbe_pkg::OP_READ, pack_word(10'd1, 0, 0, 0, 0, 0, 0, 0));
        send_word(sgbe_pkg::OP_READ, pack_word(10'd3, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();
        write_reg(sgbe_pkg::CFG_BASIS_MODE, 11'd1);
        send_word(sgbe_pkg::OP_EVAL,
                  pack_word(0, 0, 0, 0, 0, 0, 25'h0800000, 25'h1000000));
        send_word(sgbe_pkg::OP_ACCUM,
                  pack_word(0, 0, 0, 0, 0, 32'h7fffffff, 25'h1ffffff, 25'd1));
        send_word(sgbe_pkg::OP_READ, pack_word(10'd2, 0, 0, 0, 0, 0, 0, 0));

        // long receiver hold-off while words keep coming
        hold_off = 1'b1;
        random_phase(10, 15);
        wait_idle();

        // random phases over several settings of mode and count
        for (int ph = 0; ph < 6; ph++) begin
            int n;
            n = (ph == 5) ? 16 : $urandom_range(0, 16);
            write_reg(sgbe_pkg::CFG_BASIS_MODE, 11'(ph[0]));
            write_reg(sgbe_pkg::CFG_GRID_COUNT, 11'(n));
            random_phase(90, n_loaded - 2);
            wait_idle();
        end

        // deepest level and largest index, walked at the full loaded count
        write_reg(sgbe_pkg::CFG_GRID_COUNT, 11'd16);
        write_reg(sgbe_pkg::CFG_BASIS_MODE, 11'd0);
        send_word(sgbe_pkg::OP_LOAD, pack_word(10'd15, 5'd16, 5'd16, 16'hffff, 16'hffff,
                  32'h80000000, 0, 0));
        random_phase(4, 14);
        wait_idle();
        repeat (50) @(posedge clk);

        $display("Covered %0d walks over %0d words, both basis modes, counts 0..16,",
                 n_evals, word_count);
        $display("with random gaps on both sides and one long receiver hold-off.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d words still expected", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
